### src/tfmb_pkg.sv
// Shared types, widths and constants for the thruster force block.
package tfmb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TS_FRAC   = 16;

  localparam int CMD_W   = 18;
  localparam int THR_W   = 17;
  localparam int STOP_W  = 32;
  localparam int TS_W    = 16;
  localparam int VEC_W   = 18;
  localparam int FORCE_W = 40;
  localparam int READ_W  = 19;
  localparam int USED_W  = 48;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Shared multiply/divide unit sizes
  localparam int ACC_W = 68;
  localparam int OPB_W = 35;
  localparam int SH_W  = 35;
  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] N_DIV_Z = 6'd34;
  localparam logic [CNT_W-1:0] N_MUL_T = 6'd33;
  localparam logic [CNT_W-1:0] N_MUL_S = 6'd16;
  localparam logic [CNT_W-1:0] N_MUL_R = 6'd18;
  localparam logic [CNT_W-1:0] N_MUL_F = 6'd22;
  localparam logic [CNT_W-1:0] N_DIV_R = 6'd19;

  localparam logic signed [READ_W-1:0] READ_MAX = 19'sd131072;
  localparam logic signed [READ_W-1:0] READ_MIN = -19'sd131072;
  localparam logic signed [READ_W-1:0] READ_ONE = 19'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THR      = 4'd0,
    REG_LOW      = 4'd1,
    REG_HIGH     = 4'd2,
    REG_BUDGET   = 4'd3,
    REG_TS       = 4'd4,
    REG_DIR_X    = 4'd5,
    REG_DIR_Y    = 4'd6,
    REG_DIR_Z    = 4'd7
  } cfg_reg_t;

  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_t;

  typedef struct packed {
    logic             start;
    mdu_op_t          op;
    logic [CNT_W-1:0] count;
  } mdu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_Z,
    S_MUL_T,
    S_MUL_S,
    S_MUL_R,
    S_MUL_F,
    S_RD_CHECK,
    S_DIV_R,
    S_EMIT
  } seq_state_t;

endpackage

### src/tfmb_if.sv
// Handshake channels: input tick items and result items.
interface tfmb_tick_if;
  logic               valid;
  logic               ready;
  logic               command_present;
  logic signed [17:0] command_value;
  logic signed [17:0] rot_00;
  logic signed [17:0] rot_01;
  logic signed [17:0] rot_02;
  logic signed [17:0] rot_10;
  logic signed [17:0] rot_11;
  logic signed [17:0] rot_12;
  logic signed [17:0] rot_20;
  logic signed [17:0] rot_21;
  logic signed [17:0] rot_22;

  modport source (
    output valid, command_present, command_value,
    output rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    input  ready
  );
  modport sink (
    input  valid, command_present, command_value,
    input  rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22,
    output ready
  );
endinterface

interface tfmb_result_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] force_x;
  logic signed [39:0] force_y;
  logic signed [39:0] force_z;
  logic               force_applied;
  logic signed [18:0] budget_reading;

  modport source (
    output valid, force_x, force_y, force_z, force_applied, budget_reading,
    input  ready
  );
  modport sink (
    input  valid, force_x, force_y, force_z, force_applied, budget_reading,
    output ready
  );
endinterface

### src/thruster_force_with_momentum_budget.sv
// Top level: sequencer, datapath registers and configuration for the thruster block.
// An off command with an unlimited budget needs no op of the shared multiply/divide unit;
// a positive budget adds the reading divide, and applied force adds the force sequence.
// One item at a time; the next is accepted once the result sits in the output register.
// Reset (synchronous): sequencer idle, momentum store zeroed, configuration registers to defaults.
module thruster_force_with_momentum_budget (
  input  logic                              clk,
  input  logic                              rst,
  tfmb_tick_if.sink                         tick,
  tfmb_result_if.source                     result,
  input  logic                              cfg_we,
  input  logic [tfmb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tfmb_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tfmb_pkg::*;

  // Configuration
  logic signed [THR_W-1:0]  thr;
  logic signed [STOP_W-1:0] low_stop;
  logic signed [STOP_W-1:0] high_stop;
  logic signed [STOP_W-1:0] budget;
  logic        [TS_W-1:0]   ts;
  logic signed [VEC_W-1:0]  dirv [0:2];

  // Sequencer
  seq_state_t state, state_next;

  // Item and working registers
  logic                      present;
  logic signed [CMD_W-1:0]   cmd;
  logic signed [VEC_W-1:0]   rot [0:8];
  logic [33:0]               z;
  logic signed [STOP_W-1:0]  thrust;
  logic signed [USED_W-1:0]  used;
  logic signed [37:0]        s_acc;
  logic signed [21:0]        d;
  logic [1:0]                ri;
  logic [1:0]                ci;
  logic signed [FORCE_W-1:0] fv [0:2];
  logic                      applied;
  logic signed [READ_W-1:0]  reading;

  // Output register
  logic                      res_valid;
  logic signed [FORCE_W-1:0] out_force [0:2];
  logic                      out_applied;
  logic signed [READ_W-1:0]  out_reading;

  // Shared unit
  mdu_ctl_t         mdu_ctl;
  mdu_stat_t        mdu_stat;
  logic [ACC_W-1:0] mdu_acc_init;
  logic [OPB_W-1:0] mdu_opb;
  logic [SH_W-1:0]  mdu_sh_init;
  logic [ACC_W-1:0] mdu_acc;
  logic [SH_W-1:0]  mdu_sh;
  logic             run;
  logic             emit_load;

  tfmb_mdu u_mdu (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mdu_ctl),
    .acc_init (mdu_acc_init),
    .opb      (mdu_opb),
    .sh_init  (mdu_sh_init),
    .acc      (mdu_acc),
    .sh       (mdu_sh),
    .stat     (mdu_stat)
  );

  // ---------------- datapath combinational ----------------
  logic signed [18:0] cmd_x;
  logic signed [18:0] thr_x;
  logic signed [18:0] cmd_off;
  logic               cmd_ge;
  logic signed [18:0] den;
  logic               den_pos;
  logic [33:0]        num;
  logic signed [32:0] diff;
  logic [33:0]        diff_n;
  logic [32:0]        adiff;
  logic               bud_pos;

  logic [32:0]        t_n;
  logic [31:0]        t_abs;
  logic [3:0]         k;
  logic signed [VEC_W-1:0] rot_sel;
  logic signed [VEC_W-1:0] dir_sel;
  logic [18:0]        rot_n;
  logic [17:0]        rot_abs;
  logic [18:0]        dir_n;
  logic [17:0]        dir_abs;
  logic [22:0]        d_n;
  logic [21:0]        d_abs;
  logic [48:0]        used_n;
  logic [47:0]        used_abs;
  logic [48:0]        mag;

  logic               p_ovf;
  logic signed [64:0] zmag;
  logic signed [64:0] zd;
  logic signed [64:0] zsh;
  logic signed [64:0] tsum;
  logic signed [STOP_W-1:0] thrust_new;

  logic signed [48:0] smag;
  logic signed [48:0] sprod;
  logic signed [48:0] step;
  logic signed [49:0] nu_full;
  logic signed [USED_W-1:0] nu;
  logic               refused;

  logic signed [37:0] tmag;
  logic signed [37:0] term;
  logic signed [37:0] s_new;

  logic signed [56:0] fmag;
  logic signed [56:0] fneg;
  logic signed [40:0] fsh;
  logic signed [FORCE_W-1:0] f_new;

  logic               rd_sat;
  logic signed [20:0] ratio;
  logic signed [20:0] rsum;
  logic signed [READ_W-1:0] rd_new;

  always_comb begin
    cmd_x   = {cmd[CMD_W-1], cmd};
    thr_x   = {{2{thr[THR_W-1]}}, thr};
    cmd_ge  = (cmd_x >= thr_x);
    cmd_off = cmd_x - thr_x;
    num     = {cmd_off[17:0], {FRAC_BITS{1'b0}}};
    den     = 19'sd65536 - thr_x;
    den_pos = !den[18] && (den != 19'sd0);
    diff    = {high_stop[STOP_W-1], high_stop} - {low_stop[STOP_W-1], low_stop};
    diff_n  = -{diff[32], diff};
    adiff   = diff[32] ? diff_n[32:0] : diff[32:0];
    bud_pos = !budget[STOP_W-1] && (budget != '0);

    t_n      = -{thrust[STOP_W-1], thrust};
    t_abs    = thrust[STOP_W-1] ? t_n[31:0] : thrust[31:0];
    k        = {1'b0, ri, 1'b0} + {2'b00, ri} + {2'b00, ci};
    rot_sel  = rot[k];
    dir_sel  = dirv[ci];
    rot_n    = -{rot_sel[VEC_W-1], rot_sel};
    rot_abs  = rot_sel[VEC_W-1] ? rot_n[17:0] : rot_sel[17:0];
    dir_n    = -{dir_sel[VEC_W-1], dir_sel};
    dir_abs  = dir_sel[VEC_W-1] ? dir_n[17:0] : dir_sel[17:0];
    d_n      = -{d[21], d};
    d_abs    = d[21] ? d_n[21:0] : d[21:0];
    used_n   = -{used[USED_W-1], used};
    used_abs = used[USED_W-1] ? used_n[47:0] : used[47:0];
    mag      = {used_abs, 1'b0};

    // Thrust from |z*diff|: saturate when the product leaves 63 bits
    p_ovf = |mdu_acc[67:63];
    zmag  = {2'b00, mdu_acc[62:0]};
    zd    = diff[32] ? -zmag : zmag;
    zsh   = zd >>> FRAC_BITS;
    tsum  = {{33{low_stop[STOP_W-1]}}, low_stop} + zsh;
    if (p_ovf) begin
      thrust_new = diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (tsum > 65'sd2147483647) begin
      thrust_new = 32'sh7FFF_FFFF;
    end else if (tsum < -65'sd2147483648) begin
      thrust_new = 32'sh8000_0000;
    end else begin
      thrust_new = tsum[31:0];
    end

    // Momentum step and saturated new total
    smag    = {1'b0, mdu_acc[47:0]};
    sprod   = thrust[STOP_W-1] ? -smag : smag;
    step    = sprod >>> TS_FRAC;
    nu_full = {{2{used[USED_W-1]}}, used} + {step[48], step};
    if (nu_full > 50'sh0_7FFF_FFFF_FFFF) begin
      nu = 48'sh7FFF_FFFF_FFFF;
    end else if (nu_full < -50'sh0_8000_0000_0000) begin
      nu = 48'sh8000_0000_0000;
    end else begin
      nu = nu_full[47:0];
    end
    refused = (nu > $signed({{16{budget[STOP_W-1]}}, budget}));

    // Row accumulation of R*dir
    tmag  = {2'b00, mdu_acc[35:0]};
    term  = (rot_sel[VEC_W-1] ^ dir_sel[VEC_W-1]) ? -tmag : tmag;
    s_new = ((ci == 2'd0) ? 38'sd0 : s_acc) + term;

    // Force component: floor(-(d*T) >> FRAC_BITS), saturated
    fmag = {1'b0, mdu_acc[55:0]};
    fneg = (d[21] ^ thrust[STOP_W-1]) ? fmag : -fmag;
    fsh  = fneg[56:16];
    if (fsh > 41'sd549755813887) begin
      f_new = 40'sh7F_FFFF_FFFF;
    end else if (fsh < -41'sd549755813888) begin
      f_new = 40'sh80_0000_0000;
    end else begin
      f_new = fsh[39:0];
    end

    // Budget reading
    rd_sat = (mag >= {15'b0, budget[30:0], 3'b000});
    ratio  = used[USED_W-1] ? -{2'b00, mdu_sh[18:0]} : {2'b00, mdu_sh[18:0]};
    rsum   = 21'sd65536 - ratio;
    if (rsum > 21'sd131072) begin
      rd_new = READ_MAX;
    end else if (rsum < -21'sd131072) begin
      rd_new = READ_MIN;
    end else begin
      rd_new = rsum[18:0];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tick.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!present || !cmd_ge) state_next = S_RD_CHECK;
        else if (den_pos)        state_next = S_DIV_Z;
        else                     state_next = S_MUL_T;
      end
      S_DIV_Z: begin
        if (mdu_stat.done) state_next = S_MUL_T;
      end
      S_MUL_T: begin
        if (mdu_stat.done) state_next = bud_pos ? S_MUL_S : S_MUL_R;
      end
      S_MUL_S: begin
        if (mdu_stat.done) state_next = refused ? S_RD_CHECK : S_MUL_R;
      end
      S_MUL_R: begin
        if (mdu_stat.done && ci == 2'd2) state_next = S_MUL_F;
      end
      S_MUL_F: begin
        if (mdu_stat.done) state_next = (ri == 2'd2) ? S_RD_CHECK : S_MUL_R;
      end
      S_RD_CHECK: begin
        state_next = (bud_pos && !rd_sat) ? S_DIV_R : S_EMIT;
      end
      S_DIV_R: begin
        if (mdu_stat.done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!res_valid || result.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    run          = 1'b0;
    mdu_ctl.op   = MDU_MUL;
    mdu_ctl.count = N_MUL_R;
    mdu_acc_init = '0;
    mdu_opb      = '0;
    mdu_sh_init  = '0;
    case (state)
      S_DIV_Z: begin
        run           = 1'b1;
        mdu_ctl.op    = MDU_DIV;
        mdu_ctl.count = N_DIV_Z;
        mdu_opb       = {17'b0, den[17:0]};
        mdu_sh_init   = {num, 1'b0};
      end
      S_MUL_T: begin
        run           = 1'b1;
        mdu_ctl.count = N_MUL_T;
        mdu_opb       = {1'b0, z};
        mdu_sh_init   = {adiff, 2'b00};
      end
      S_MUL_S: begin
        run           = 1'b1;
        mdu_ctl.count = N_MUL_S;
        mdu_opb       = {3'b000, t_abs};
        mdu_sh_init   = {ts, 19'b0};
      end
      S_MUL_R: begin
        run           = 1'b1;
        mdu_ctl.count = N_MUL_R;
        mdu_opb       = {17'b0, dir_abs};
        mdu_sh_init   = {rot_abs, 17'b0};
      end
      S_MUL_F: begin
        run           = 1'b1;
        mdu_ctl.count = N_MUL_F;
        mdu_opb       = {3'b000, t_abs};
        mdu_sh_init   = {d_abs, 13'b0};
      end
      S_DIV_R: begin
        run           = 1'b1;
        mdu_ctl.op    = MDU_DIV;
        mdu_ctl.count = N_DIV_R;
        mdu_opb       = {4'b0, budget[30:0]};
        mdu_acc_init  = {22'b0, mag[48:3]};
        mdu_sh_init   = {mag[2:0], 32'b0};
      end
      default: begin
        run = 1'b0;
      end
    endcase
    mdu_ctl.start = run && !mdu_stat.busy && !mdu_stat.done;
    tick.ready    = (state == S_IDLE);
    emit_load     = (state == S_EMIT) && (!res_valid || result.ready);
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= 17'sd0;
      low_stop  <= 32'sd0;
      high_stop <= 32'sd65536;
      budget    <= -32'sd65536;
      ts        <= 16'd328;
      dirv[0]   <= 18'sd0;
      dirv[1]   <= 18'sd0;
      dirv[2]   <= 18'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THR:    thr       <= cfg_data[THR_W-1:0];
        REG_LOW:    low_stop  <= cfg_data[STOP_W-1:0];
        REG_HIGH:   high_stop <= cfg_data[STOP_W-1:0];
        REG_BUDGET: budget    <= cfg_data[STOP_W-1:0];
        REG_TS:     ts        <= cfg_data[TS_W-1:0];
        REG_DIR_X:  dirv[0]   <= cfg_data[VEC_W-1:0];
        REG_DIR_Y:  dirv[1]   <= cfg_data[VEC_W-1:0];
        REG_DIR_Z:  dirv[2]   <= cfg_data[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- momentum store ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (state == S_MUL_S && mdu_stat.done && !refused) begin
      used <= nu;
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      present <= tick.command_present;
      cmd     <= tick.command_value;
      rot[0]  <= tick.rot_00;
      rot[1]  <= tick.rot_01;
      rot[2]  <= tick.rot_02;
      rot[3]  <= tick.rot_10;
      rot[4]  <= tick.rot_11;
      rot[5]  <= tick.rot_12;
      rot[6]  <= tick.rot_20;
      rot[7]  <= tick.rot_21;
      rot[8]  <= tick.rot_22;
    end
    case (state)
      S_CHECK: begin
        // full command when the span above the threshold is empty
        z       <= 34'(1) << FRAC_BITS;
        applied <= 1'b0;
        fv[0]   <= '0;
        fv[1]   <= '0;
        fv[2]   <= '0;
        ri      <= 2'd0;
        ci      <= 2'd0;
      end
      S_DIV_Z: begin
        if (mdu_stat.done) z <= mdu_sh[33:0];
      end
      S_MUL_T: begin
        if (mdu_stat.done) thrust <= thrust_new;
      end
      S_MUL_R: begin
        if (mdu_stat.done) begin
          s_acc <= s_new;
          if (ci == 2'd2) begin
            d  <= s_new[37:16];
            ci <= 2'd0;
          end else begin
            ci <= ci + 2'd1;
          end
        end
      end
      S_MUL_F: begin
        if (mdu_stat.done) begin
          fv[ri] <= f_new;
          if (ri == 2'd2) begin
            applied <= 1'b1;
          end else begin
            ri <= ri + 2'd1;
          end
        end
      end
      S_RD_CHECK: begin
        if (!bud_pos) begin
          reading <= READ_ONE;
        end else if (rd_sat) begin
          reading <= used[USED_W-1] ? READ_MAX : READ_MIN;
        end
      end
      S_DIV_R: begin
        if (mdu_stat.done) reading <= rd_new;
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_force[0] <= fv[0];
      out_force[1] <= fv[1];
      out_force[2] <= fv[2];
      out_applied  <= applied;
      out_reading  <= reading;
    end
  end

  assign result.valid          = res_valid;
  assign result.force_x        = out_force[0];
  assign result.force_y        = out_force[1];
  assign result.force_z        = out_force[2];
  assign result.force_applied  = out_applied;
  assign result.budget_reading = out_reading;

endmodule

### src/tfmb_mdu.sv
// Shared bit-serial multiply / restoring divide unit, one bit per cycle.
module tfmb_mdu (
  input  logic                     clk,
  input  logic                     rst,
  input  tfmb_pkg::mdu_ctl_t       ctl,
  input  logic [tfmb_pkg::ACC_W-1:0] acc_init,
  input  logic [tfmb_pkg::OPB_W-1:0] opb,
  input  logic [tfmb_pkg::SH_W-1:0]  sh_init,
  output logic [tfmb_pkg::ACC_W-1:0] acc,
  output logic [tfmb_pkg::SH_W-1:0]  sh,
  output tfmb_pkg::mdu_stat_t      stat
);
  import tfmb_pkg::*;

  logic [OPB_W-1:0] opb_r;
  mdu_op_t          op_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic             top_bit;
  logic             is_div;
  logic [ACC_W-1:0] shifted;
  logic [ACC_W:0]   addend;
  logic [ACC_W:0]   res;
  logic             fits;
  logic [ACC_W-1:0] acc_next;
  logic [SH_W-1:0]  sh_next;

  always_comb begin
    top_bit = sh[SH_W-1];
    is_div  = (op_r == MDU_DIV);
    shifted = {acc[ACC_W-2:0], is_div & top_bit};
    // Divide: subtract divisor; multiply: add multiplicand when the bit is set
    if (is_div) begin
      addend = ~{{(ACC_W+1-OPB_W){1'b0}}, opb_r};
    end else begin
      addend = top_bit ? {{(ACC_W+1-OPB_W){1'b0}}, opb_r} : '0;
    end
    res  = {1'b0, shifted} + addend + {{ACC_W{1'b0}}, is_div};
    fits = ~res[ACC_W];
    if (is_div && !fits) begin
      acc_next = shifted;
    end else begin
      acc_next = res[ACC_W-1:0];
    end
    sh_next = {sh[SH_W-2:0], is_div & fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc   <= acc_init;
      sh    <= sh_init;
      opb_r <= opb;
      op_r  <= ctl.op;
    end else if (busy) begin
      acc <= acc_next;
      sh  <= sh_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### src/tfmb_checker.sv
// Port-level checks for the thruster force block, bound to the top level.
module tfmb_checker (
  input logic               clk,
  input logic               rst,
  input logic               tick_valid,
  input logic               tick_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic signed [39:0] force_x,
  input logic signed [39:0] force_y,
  input logic signed [39:0] force_z,
  input logic               force_applied,
  input logic signed [18:0] budget_reading
);

  // Block turns busy right after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("ready still high after an item was accepted");

  // No force unless it is flagged as applied
  a_zero_when_off: assert property (@(posedge clk) disable iff (rst)
    res_valid && !force_applied |-> force_x == 40'sd0 && force_y == 40'sd0 &&
                                    force_z == 40'sd0)
    else $error("nonzero force on an item with no force applied");

  // A new result only shows up out of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!tick_ready))
    else $error("result appeared while the block was idle");

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(force_x) && $stable(force_y) &&
                               $stable(force_z) && $stable(force_applied) &&
                               $stable(budget_reading))
    else $error("stalled result changed or dropped");

endmodule

bind thruster_force_with_momentum_budget tfmb_checker u_tfmb_checker (
  .clk            (clk),
  .rst            (rst),
  .tick_valid     (tick.valid),
  .tick_ready     (tick.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .force_x        (result.force_x),
  .force_y        (result.force_y),
  .force_z        (result.force_z),
  .force_applied  (result.force_applied),
  .budget_reading (result.budget_reading)
);
